FILE: hdl/fmppt_pkg.sv
// Shared types and constants for the fuzzy MPPT pulse-width controller.
// Holds bin codes, rule levels, the rule table, register indexes and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package fmppt_pkg;

   // External field widths
   localparam int SAMPLE_W = 16;
   localparam int WIDTH_W  = 16;
   localparam int LEVEL_W  = 3;
   localparam int THRESH_W = 31;
   localparam int WEIGHT_W = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BIG_THRESHOLD    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEDIUM_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SMALL_WEIGHT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MEDIUM_WEIGHT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WIDTH        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WIDTH        = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_START_WIDTH      = 3'd7;

   // Register reset values
   localparam logic [THRESH_W-1:0] BIG_THRESHOLD_RST    = 31'd100;
   localparam logic [THRESH_W-1:0] MEDIUM_THRESHOLD_RST = 31'd10;
   localparam logic [WEIGHT_W-1:0] SMALL_WEIGHT_RST     = 9'd90;
   localparam logic [WEIGHT_W-1:0] MEDIUM_WEIGHT_RST    = 9'd179;
   localparam logic [WEIGHT_W-1:0] FULL_WEIGHT          = 9'd256;
   localparam logic [WIDTH_W-1:0]  STEP_SIZE_RST        = 16'd1;
   localparam logic [WIDTH_W-1:0]  MIN_WIDTH_RST        = 16'd0;
   localparam logic [WIDTH_W-1:0]  MAX_WIDTH_RST        = 16'hFFFF;
   localparam logic [WIDTH_W-1:0]  START_WIDTH_RST      = 16'd0;

   // Fuzzy bins of slope and slope change
   typedef logic [2:0] bin_type;
   localparam bin_type BIN_NB = 3'd0;
   localparam bin_type BIN_NM = 3'd1;
   localparam bin_type BIN_NS = 3'd2;
   localparam bin_type BIN_Z  = 3'd3;
   localparam bin_type BIN_PS = 3'd4;
   localparam bin_type BIN_PM = 3'd5;
   localparam bin_type BIN_PB = 3'd6;

   // Rule levels
   typedef logic signed [LEVEL_W-1:0] level_type;
   localparam level_type LVL_NB = 3'sb101;
   localparam level_type LVL_NM = 3'sb110;
   localparam level_type LVL_NS = 3'sb111;
   localparam level_type LVL_Z  = 3'sb000;
   localparam level_type LVL_PS = 3'sb001;
   localparam level_type LVL_PM = 3'sb010;
   localparam level_type LVL_PB = 3'sb011;

   // Rule table, row = slope bin, column = slope change bin
   localparam level_type RULE_TABLE [0:6][0:6] = '{
      '{LVL_NB, LVL_NB, LVL_NB, LVL_NB, LVL_NM, LVL_NS, LVL_Z },
      '{LVL_NB, LVL_NB, LVL_NB, LVL_NM, LVL_NS, LVL_Z,  LVL_PS},
      '{LVL_NB, LVL_NB, LVL_NM, LVL_NS, LVL_Z,  LVL_PS, LVL_PM},
      '{LVL_NB, LVL_NM, LVL_NS, LVL_Z,  LVL_PS, LVL_PM, LVL_PB},
      '{LVL_NM, LVL_NS, LVL_Z,  LVL_PS, LVL_PM, LVL_PB, LVL_PB},
      '{LVL_NS, LVL_Z,  LVL_PS, LVL_PM, LVL_PB, LVL_PB, LVL_PB},
      '{LVL_Z,  LVL_PS, LVL_PM, LVL_PB, LVL_PB, LVL_PB, LVL_PB}
   };

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic mul;
      logic diff;
      logic div_start;
      logic slope;
      logic dslope;
      logic rule;
      logic scale;
      logic commit;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic div_done;
      logic out_free;
   } status_type;

endpackage

FILE: hdl/fuzzy_mppt_duty_controller_unit.sv
// Fuzzy MPPT pulse-width controller, top level.
// A request is accepted in idle, then multiplied, differenced, divided for the
// slope dP/dV by the one-bit-per-cycle divider, binned, looked up, scaled and
// committed once the result slot is free. One request is in flight at a time;
// the result register lets the next request in while a result waits. Synchronous
// active-high reset restores register defaults, clears history and loads the start width.
`timescale 1ns / 1ps

module fuzzy_mppt_duty_controller_unit #(
   parameter int SAMPLE_BITS = 16,
   parameter int SLOPE_BITS  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [fmppt_pkg::SAMPLE_W-1:0]       req_out_voltage,
   input  logic [fmppt_pkg::SAMPLE_W-1:0]       req_out_current,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [fmppt_pkg::WIDTH_W-1:0]        rsp_pulse_width,
   output logic signed [fmppt_pkg::LEVEL_W-1:0] rsp_rule_level,
   input  logic                                 csr_write_en,
   input  logic [fmppt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fmppt_pkg::CSR_DATA_W-1:0]     csr_data
);

   fmppt_pkg::cmd_type    cmd;
   fmppt_pkg::status_type status;

   fmppt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   fmppt_dpath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SLOPE_BITS  (SLOPE_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_out_voltage (req_out_voltage),
      .req_out_current (req_out_current),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pulse_width (rsp_pulse_width),
      .rsp_rule_level  (rsp_rule_level)
   );

endmodule

FILE: hdl/fmppt_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Used by the datapath for the slope quotient. No package dependencies.
`timescale 1ns / 1ps

module fmppt_div #(
   parameter int DVD_BITS = 32,
   parameter int DVS_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DVD_BITS-1:0] dividend,
   input  logic [DVS_BITS-1:0] divisor,
   output logic [DVD_BITS-1:0] quotient,
   output logic                done
);

   localparam int CNT_W = $clog2(DVD_BITS + 1);

   logic [DVS_BITS-1:0] rem_ff, rem_in;
   logic [DVD_BITS-1:0] quo_ff, quo_in;
   logic [DVS_BITS-1:0] dvs_ff;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [DVS_BITS:0]   trial;
   logic [DVS_BITS:0]   diff;
   logic                ge;

   // One restoring step: shift in next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, quo_ff[DVD_BITS-1]};
      diff  = trial - {1'b0, dvs_ff};
      ge    = (trial >= {1'b0, dvs_ff});
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CNT_W'(DVD_BITS);
         done_in = 1'b0;
      end else if (cnt_ff != '0) begin
         rem_in = ge ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
         quo_in = {quo_ff[DVD_BITS-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   // Hold divisor for the whole run
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

FILE: hdl/fmppt_dpath.sv
// Datapath: configuration registers, tracker state, power/slope arithmetic,
// binning, rule lookup, width update and the result register.
// Depends on fmppt_pkg and fmppt_div.
`timescale 1ns / 1ps

module fmppt_dpath #(
   parameter int SAMPLE_BITS = 16,
   parameter int SLOPE_BITS  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fmppt_pkg::cmd_type                   cmd,
   output fmppt_pkg::status_type                status,
   input  logic [fmppt_pkg::SAMPLE_W-1:0]       req_out_voltage,
   input  logic [fmppt_pkg::SAMPLE_W-1:0]       req_out_current,
   input  logic                                 csr_write_en,
   input  logic [fmppt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fmppt_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [fmppt_pkg::WIDTH_W-1:0]        rsp_pulse_width,
   output logic signed [fmppt_pkg::LEVEL_W-1:0] rsp_rule_level
);

   localparam int SW = SAMPLE_BITS;
   localparam int SB = SLOPE_BITS;
   localparam int PW = 2 * SAMPLE_BITS;
   localparam int EW = ((PW > SB) ? PW : SB) + 2;
   localparam int CW = ((SB > fmppt_pkg::THRESH_W) ? SB : fmppt_pkg::THRESH_W) + 2;
   localparam int AW = fmppt_pkg::WIDTH_W + 1;
   localparam int MW = fmppt_pkg::WEIGHT_W + fmppt_pkg::WIDTH_W;
   localparam int UW = fmppt_pkg::WIDTH_W + 3;

   localparam logic [EW-1:0]        SMAX_W = (EW'(1) << (SB - 1)) - EW'(1);
   localparam logic signed [SB-1:0] SMAX_S = {1'b0, {(SB - 1){1'b1}}};
   localparam logic signed [SB-1:0] SMIN_S = {1'b1, {(SB - 1){1'b0}}};

   // Configuration registers
   logic [fmppt_pkg::THRESH_W-1:0] big_thr_ff, med_thr_ff;
   logic [fmppt_pkg::WEIGHT_W-1:0] small_wt_ff, med_wt_ff;
   logic [fmppt_pkg::WIDTH_W-1:0]  step_ff, min_w_ff, max_w_ff;

   // Tracker state
   logic [SW-1:0]                 prev_v_ff;
   logic [PW-1:0]                 prev_p_ff;
   logic signed [SB-1:0]          prev_slope_ff;
   logic [fmppt_pkg::WIDTH_W-1:0] width_now_ff;

   // Working registers
   logic [SW-1:0]            v_ff, i_ff;
   logic [PW-1:0]            p_ff;
   logic                     dp_neg_ff, dv_neg_ff;
   logic [PW-1:0]            dp_mag_ff;
   logic [SW-1:0]            dv_mag_ff;
   logic signed [SB-1:0]     e_ff, e_in;
   logic signed [SB-1:0]     de_ff, de_in;
   fmppt_pkg::level_type     level_ff;
   logic [AW-1:0]            amount_ff;

   // Result register
   logic                          rsp_valid_ff;
   logic [fmppt_pkg::WIDTH_W-1:0] rsp_width_ff;
   fmppt_pkg::level_type          rsp_level_ff;

   // Combinational intermediates
   logic [PW:0]              dp_w, dp_abs;
   logic [SW:0]              dv_w, dv_abs;
   logic [PW-1:0]            quotient;
   logic                     div_done;
   logic [EW-1:0]            q_w;
   logic                     q_neg;
   logic signed [SB:0]       de_w;
   fmppt_pkg::bin_type       bin_e, bin_de;
   logic [fmppt_pkg::WEIGHT_W-1:0] weight;
   logic [MW-1:0]            prod;
   logic signed [UW-1:0]     w_sum, w_min, w_max;
   logic [fmppt_pkg::WIDTH_W-1:0]  w_clamped;

   // Sort a slope value into one of seven bins
   function automatic fmppt_pkg::bin_type bin_of(
      input logic signed [SB-1:0]          x,
      input logic [fmppt_pkg::THRESH_W-1:0] big,
      input logic [fmppt_pkg::THRESH_W-1:0] med
   );
      logic signed [CW-1:0] xw;
      logic signed [CW-1:0] bg;
      logic signed [CW-1:0] md;
      logic signed [CW-1:0] zero;
      fmppt_pkg::bin_type   b;
      xw   = CW'(x);
      bg   = signed'(CW'(big));
      md   = signed'(CW'(med));
      zero = '0;
      if (xw == zero) begin
         b = fmppt_pkg::BIN_Z;
      end else if (xw > bg) begin
         b = fmppt_pkg::BIN_PB;
      end else if (xw > zero) begin
         b = (xw > md) ? fmppt_pkg::BIN_PM : fmppt_pkg::BIN_PS;
      end else if (xw < -bg) begin
         b = fmppt_pkg::BIN_NB;
      end else if ((xw < -md) && (xw > -bg)) begin
         b = fmppt_pkg::BIN_NM;
      end else begin
         b = fmppt_pkg::BIN_NS;
      end
      return b;
   endfunction

   // Configuration writes; the start width goes straight to the tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         big_thr_ff  <= fmppt_pkg::BIG_THRESHOLD_RST;
         med_thr_ff  <= fmppt_pkg::MEDIUM_THRESHOLD_RST;
         small_wt_ff <= fmppt_pkg::SMALL_WEIGHT_RST;
         med_wt_ff   <= fmppt_pkg::MEDIUM_WEIGHT_RST;
         step_ff     <= fmppt_pkg::STEP_SIZE_RST;
         min_w_ff    <= fmppt_pkg::MIN_WIDTH_RST;
         max_w_ff    <= fmppt_pkg::MAX_WIDTH_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            fmppt_pkg::CSR_BIG_THRESHOLD: begin
               big_thr_ff <= csr_data;
            end
            fmppt_pkg::CSR_MEDIUM_THRESHOLD: begin
               med_thr_ff <= csr_data;
            end
            fmppt_pkg::CSR_SMALL_WEIGHT: begin
               small_wt_ff <= csr_data[fmppt_pkg::WEIGHT_W-1:0];
            end
            fmppt_pkg::CSR_MEDIUM_WEIGHT: begin
               med_wt_ff <= csr_data[fmppt_pkg::WEIGHT_W-1:0];
            end
            fmppt_pkg::CSR_STEP_SIZE: begin
               step_ff <= csr_data[fmppt_pkg::WIDTH_W-1:0];
            end
            fmppt_pkg::CSR_MIN_WIDTH: begin
               min_w_ff <= csr_data[fmppt_pkg::WIDTH_W-1:0];
            end
            fmppt_pkg::CSR_MAX_WIDTH: begin
               max_w_ff <= csr_data[fmppt_pkg::WIDTH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Differences against the previous sample, as sign and magnitude
   always_comb begin
      dp_w   = {1'b0, p_ff} - {1'b0, prev_p_ff};
      dp_abs = dp_w[PW] ? ((~dp_w) + (PW + 1)'(1)) : dp_w;
      dv_w   = {1'b0, v_ff} - {1'b0, prev_v_ff};
      dv_abs = dv_w[SW] ? ((~dv_w) + (SW + 1)'(1)) : dv_w;
   end

   fmppt_div #(
      .DVD_BITS (PW),
      .DVS_BITS (SW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dp_mag_ff),
      .divisor  (dv_mag_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   // Signed, saturated slope; zero voltage change takes the sign of dP
   always_comb begin
      q_w   = EW'(quotient);
      q_neg = dp_neg_ff ^ dv_neg_ff;
      if (dv_mag_ff == '0) begin
         if (dp_mag_ff == '0) begin
            e_in = '0;
         end else begin
            e_in = dp_neg_ff ? SMIN_S : SMAX_S;
         end
      end else if (!q_neg) begin
         e_in = (q_w > SMAX_W) ? SMAX_S : signed'(SB'(q_w));
      end else begin
         e_in = (q_w > (SMAX_W + EW'(1))) ? SMIN_S : signed'(SB'(-q_w));
      end
   end

   // Saturated slope change
   always_comb begin
      de_w = {e_ff[SB-1], e_ff} - {prev_slope_ff[SB-1], prev_slope_ff};
      if (de_w[SB] != de_w[SB-1]) begin
         de_in = de_w[SB] ? SMIN_S : SMAX_S;
      end else begin
         de_in = de_w[SB-1:0];
      end
   end

   always_comb begin
      bin_e  = bin_of(e_ff, big_thr_ff, med_thr_ff);
      bin_de = bin_of(de_ff, big_thr_ff, med_thr_ff);
   end

   // Level weight times step size, floored
   always_comb begin
      case (level_ff)
         fmppt_pkg::LVL_PB, fmppt_pkg::LVL_NB: weight = fmppt_pkg::FULL_WEIGHT;
         fmppt_pkg::LVL_PM, fmppt_pkg::LVL_NM: weight = med_wt_ff;
         fmppt_pkg::LVL_PS, fmppt_pkg::LVL_NS: weight = small_wt_ff;
         default:                              weight = '0;
      endcase
      prod = MW'(weight) * MW'(step_ff);
   end

   // Apply the step and clamp; when bounds cross, a sum below the lower bound takes it and any other takes the upper
   always_comb begin
      if (level_ff[fmppt_pkg::LEVEL_W-1]) begin
         w_sum = signed'(UW'(width_now_ff)) - signed'(UW'(amount_ff));
      end else begin
         w_sum = signed'(UW'(width_now_ff)) + signed'(UW'(amount_ff));
      end
      w_min = signed'(UW'(min_w_ff));
      w_max = signed'(UW'(max_w_ff));
      if (w_sum < w_min) begin
         w_clamped = min_w_ff;
      end else if (w_sum > w_max) begin
         w_clamped = max_w_ff;
      end else begin
         w_clamped = w_sum[fmppt_pkg::WIDTH_W-1:0];
      end
   end

   // Working registers, loaded one stage at a time
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         v_ff <= SW'(req_out_voltage);
         i_ff <= SW'(req_out_current);
      end
      if (cmd.mul) begin
         p_ff <= PW'(v_ff) * PW'(i_ff);
      end
      if (cmd.diff) begin
         dp_neg_ff <= dp_w[PW];
         dp_mag_ff <= dp_abs[PW-1:0];
         dv_neg_ff <= dv_w[SW];
         dv_mag_ff <= dv_abs[SW-1:0];
      end
      if (cmd.slope) begin
         e_ff <= e_in;
      end
      if (cmd.dslope) begin
         de_ff <= de_in;
      end
      if (cmd.rule) begin
         level_ff <= fmppt_pkg::RULE_TABLE[bin_e][bin_de];
      end
      if (cmd.scale) begin
         amount_ff <= prod[MW-1:8];
      end
      if (cmd.commit) begin
         rsp_width_ff <= w_clamped;
         rsp_level_ff <= level_ff;
      end
   end

   // Tracker state: advance on commit, reload width on start width write
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_v_ff     <= '0;
         prev_p_ff     <= '0;
         prev_slope_ff <= '0;
         width_now_ff  <= fmppt_pkg::START_WIDTH_RST;
      end else if (cmd.commit) begin
         prev_v_ff     <= v_ff;
         prev_p_ff     <= p_ff;
         prev_slope_ff <= e_ff;
         width_now_ff  <= w_clamped;
      end else if (csr_write_en && (csr_index == fmppt_pkg::CSR_START_WIDTH)) begin
         width_now_ff <= csr_data[fmppt_pkg::WIDTH_W-1:0];
      end
   end

   // Result valid: set on commit, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pulse_width = rsp_width_ff;
   assign rsp_rule_level  = rsp_level_ff;

endmodule

FILE: hdl/fmppt_ctrl.sv
// Controller state machine: sequences the datapath one request at a time.
// Depends on fmppt_pkg for the command and status structs.
`timescale 1ns / 1ps

module fmppt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output fmppt_pkg::cmd_type    cmd,
   input  fmppt_pkg::status_type status
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MUL    = 4'd1;
   localparam logic [3:0] ST_DIFF   = 4'd2;
   localparam logic [3:0] ST_START  = 4'd3;
   localparam logic [3:0] ST_WAIT   = 4'd4;
   localparam logic [3:0] ST_SLOPE  = 4'd5;
   localparam logic [3:0] ST_DSLOPE = 4'd6;
   localparam logic [3:0] ST_RULE   = 4'd7;
   localparam logic [3:0] ST_SCALE  = 4'd8;
   localparam logic [3:0] ST_WRITE  = 4'd9;

   logic [3:0] state_ff, state_in;

   // Advance through the fixed sequence; wait on divider and result slot
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MUL;
         ST_MUL:    state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_START;
         ST_START:  state_in = ST_WAIT;
         ST_WAIT:   if (status.div_done) state_in = ST_SLOPE;
         ST_SLOPE:  state_in = ST_DSLOPE;
         ST_DSLOPE: state_in = ST_RULE;
         ST_RULE:   state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_WRITE;
         ST_WRITE:  if (status.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands
   always_comb begin
      cmd.capture   = (state_ff == ST_IDLE) && req_valid;
      cmd.mul       = (state_ff == ST_MUL);
      cmd.diff      = (state_ff == ST_DIFF);
      cmd.div_start = (state_ff == ST_START);
      cmd.slope     = (state_ff == ST_SLOPE);
      cmd.dslope    = (state_ff == ST_DSLOPE);
      cmd.rule      = (state_ff == ST_RULE);
      cmd.scale     = (state_ff == ST_SCALE);
      cmd.commit    = (state_ff == ST_WRITE) && status.out_free;
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule
